// ===== hdl/sitda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_pkg
// Shared types and constants of the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package sitda_pkg;

  localparam int VALUE_W    = 32;
  localparam int CHAR_W     = 6;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 10;
  localparam int BIT_CNT_W  = $clog2(VALUE_W);
  localparam int REM_W      = $clog2(NUM_DIGITS + 1);

  localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
  localparam logic [CHAR_W-1:0] MINUS_CODE = 6'd45;

  typedef struct packed {
    logic clear;
    logic bit_shift;
    logic digit_shift;
  } cell_ctrl_t;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_CONVERT = 5'b00010,
    S_SKIP    = 5'b00100,
    S_SIGN    = 5'b01000,
    S_EMIT    = 5'b10000
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/sitda_bcd_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sitda_bcd_cell
// One decimal digit of the conversion chain: add-3 and shift during binary
// to BCD conversion, whole-digit shift toward the top in skip and emission.
// ----------------------------------------------------------------------------
module sitda_bcd_cell (
  input  wire                         clk,
  input  wire  sitda_pkg::cell_ctrl_t ctrl,
  input  wire                         bit_in,
  output logic                        bit_out,
  input  wire  [sitda_pkg::DIGIT_W-1:0] digit_in,
  output logic [sitda_pkg::DIGIT_W-1:0] digit
);
  import sitda_pkg::*;

  logic [DIGIT_W-1:0] adj;

  assign adj     = (digit >= 4'd5) ? digit + 4'd3 : digit;
  assign bit_out = adj[DIGIT_W-1];

  always_ff @(posedge clk) begin
    priority if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.bit_shift) begin
      digit <= {adj[DIGIT_W-2:0], bit_in};
    end else if (ctrl.digit_shift) begin
      digit <= digit_in;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/signed_int_to_decimal_ascii.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Converts one signed 32-bit integer into its decimal ASCII text.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with value. One beat is one number.
// Output channel: out_valid / out_stall with character and last. One beat is
// one character, most significant first; a negative number opens with '-',
// and last marks the final digit of each number.
// The magnitude passes bit by bit into a row of ten BCD digit cells (add-3
// and shift), leading zero digits are then shifted out one a cycle, and the
// characters leave through a single output register.
// in_stall stays high from acceptance until the last character is loaded
// into the output register; the next number is taken while that character
// still waits.
// A stalled output holds its register; during emission the digit row waits.
// Reset returns the block to idle with no output pending; no other state.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  signed [sitda_pkg::VALUE_W-1:0] value,
  output logic                          out_valid,
  input  wire                           out_stall,
  output logic [sitda_pkg::CHAR_W-1:0]  character,
  output logic                          last
);
  import sitda_pkg::*;

  state_t                 state;
  logic [VALUE_W-1:0]     mag;
  logic                   neg;
  logic [BIT_CNT_W-1:0]   bit_cnt;
  logic [REM_W-1:0]       remaining;

  logic                   in_accept;
  logic                   load_ok;
  logic                   load_char;
  logic [VALUE_W-1:0]     raw;
  cell_ctrl_t             ctrl;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   top_zero;
  logic                   one_left;

  logic [NUM_DIGITS:0]    bit_chain;
  logic [DIGIT_W-1:0]     digit_chain [NUM_DIGITS+1];

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign load_ok   = !out_valid || !out_stall;
  assign load_char = ((state == S_SIGN) || (state == S_EMIT)) && load_ok;
  assign raw       = value;
  assign top_digit = digit_chain[NUM_DIGITS];
  assign top_zero  = (top_digit == '0);
  assign one_left  = (remaining == REM_W'(1));

  assign bit_chain[0]   = mag[VALUE_W-1];
  assign digit_chain[0] = '0;

  always_comb begin
    ctrl             = '0;
    ctrl.clear       = in_accept;
    ctrl.bit_shift   = (state == S_CONVERT);
    ctrl.digit_shift = ((state == S_SKIP) && top_zero && !one_left) ||
                       ((state == S_EMIT) && load_ok);
  end

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    sitda_bcd_cell u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .bit_in   (bit_chain[i]),
      .bit_out  (bit_chain[i+1]),
      .digit_in (digit_chain[i]),
      .digit    (digit_chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (load_char) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_CONVERT;
          end
        end
        S_CONVERT: begin
          if (bit_cnt == BIT_CNT_W'(VALUE_W - 1)) begin
            state <= S_SKIP;
          end
        end
        S_SKIP: begin
          if (!top_zero || one_left) begin
            state <= neg ? S_SIGN : S_EMIT;
          end
        end
        S_SIGN: begin
          if (load_ok) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_ok && one_left) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      mag       <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
      neg       <= raw[VALUE_W-1];
      bit_cnt   <= '0;
      remaining <= REM_W'(NUM_DIGITS);
    end
    if (state == S_CONVERT) begin
      mag     <= {mag[VALUE_W-2:0], 1'b0};
      bit_cnt <= bit_cnt + BIT_CNT_W'(1);
    end
    if ((state == S_SKIP) && top_zero && !one_left) begin
      remaining <= remaining - REM_W'(1);
    end
    if ((state == S_SIGN) && load_ok) begin
      character <= MINUS_CODE;
      last      <= 1'b0;
    end
    if ((state == S_EMIT) && load_ok) begin
      character <= DIGIT_BASE + CHAR_W'(top_digit);
      last      <= one_left;
      remaining <= remaining - REM_W'(1);
    end
  end

endmodule
`default_nettype wire

// ===== dv/signed_int_to_decimal_ascii_tb.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_tb
// Drives signed 32-bit numbers into the converter and checks every character
// beat against a local prediction of the decimal text: sign, digit order and
// last flag. Covers directed edge values, back-to-back numbers, random
// numbers of every digit count with random gaps on both sides, and a long
// output hold-off that backs the converter up into its input.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_tb;
  import sitda_pkg::*;

  localparam int unsigned RADIX = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              fin;
  } glyph_t;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  logic signed [VALUE_W-1:0] value;
  logic                      out_valid;
  logic                      out_stall;
  logic [CHAR_W-1:0]         character;
  logic                      last;

  glyph_t pending_chars[$];
  int     mismatches;
  int     numbers_sent;
  int     negatives_sent;
  int     chars_checked;
  bit     tx_gaps_on;
  bit     rx_gaps_on;
  int     rx_pause_left;
  int     hold_off_left;

  signed_int_to_decimal_ascii u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .value    (value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .character(character),
    .last     (last)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void predict_text(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mag;
    int unsigned        digs[NUM_DIGITS];
    int                 n;
    glyph_t             g;
    mag = raw[VALUE_W-1] ? (~raw + 1'b1) : raw;
    n = 0;
    do begin
      digs[n] = mag % RADIX;
      mag = mag / RADIX;
      n++;
    end while (mag != 0 && n < NUM_DIGITS);
    if (raw[VALUE_W-1]) begin
      g.code = MINUS_CODE;
      g.fin  = 1'b0;
      pending_chars.push_back(g);
    end
    for (int i = n - 1; i >= 0; i--) begin
      g.code = DIGIT_BASE + CHAR_W'(digs[i]);
      g.fin  = (i == 0);
      pending_chars.push_back(g);
    end
  endfunction

  // Call at a falling edge; returns at a falling edge with valid still high.
  task automatic send_number(input logic signed [VALUE_W-1:0] v);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      value    = $urandom;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    value    = v;
    do @(posedge clk); while (in_stall);
    predict_text(v);
    numbers_sent++;
    if (v < 0) negatives_sent++;
    @(negedge clk);
  endtask

  task automatic drop_valid();
    in_valid = 1'b0;
  endtask

  function automatic logic signed [VALUE_W-1:0] random_number();
    int          d;
    longint      lo;
    longint      hi;
    longint      mag;
    bit          neg;
    neg = $urandom_range(0, 1);
    if ($urandom_range(0, 3) == 0) return $urandom;
    d  = $urandom_range(1, NUM_DIGITS);
    lo = (d == 1) ? 0 : 64'd10 ** (d - 1);
    hi = 64'd10 ** d - 1;
    if (d == NUM_DIGITS) hi = neg ? 64'd2147483648 : 64'd2147483647;
    mag = lo + ({32'd0, $urandom} % (hi - lo + 1));
    return neg ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  task automatic test_directed();
    logic signed [VALUE_W-1:0] vals[] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
      32'h7FFF_FFFF, 32'h8000_0000, 32'sd1000000000, 32'sd999999999,
      -32'sd999999999, 32'sd1234567890, 32'h5555_5555, 32'hAAAA_AAAA,
      -32'sd7, 32'h8000_0001, 32'sd5
    };
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    foreach (vals[i]) send_number(vals[i]);
    drop_valid();
  endtask

  task automatic test_back_to_back();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (20) send_number(random_number());
    drop_valid();
  endtask

  task automatic test_random_gaps();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    repeat (100) send_number(random_number());
    drop_valid();
  endtask

  task automatic test_output_hold();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    hold_off_left = 250;
    repeat (8) send_number(random_number());
    rx_gaps_on = 1'b1;
    repeat (4) send_number(random_number());
    drop_valid();
  endtask

  // Receiver: hold the output for drawn or requested stretches.
  initial begin
    out_stall = 1'b0;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else if (rx_pause_left > 0) begin
        out_stall = 1'b1;
        rx_pause_left--;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin : check_beat
    glyph_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      rx_pause_left = rx_gaps_on ? $urandom_range(0, 6) : 0;
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected beat: character=%0d last=%0b", character, last);
      end else begin
        want = pending_chars.pop_front();
        if (character !== want.code || last !== want.fin) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected character=%0d last=%0b, got character=%0d last=%0b",
                     want.code, want.fin, character, last);
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    value          = '0;
    mismatches     = 0;
    numbers_sent   = 0;
    negatives_sent = 0;
    chars_checked  = 0;
    tx_gaps_on     = 1'b0;
    rx_gaps_on     = 1'b0;
    rx_pause_left  = 0;
    hold_off_left  = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_directed();
    test_back_to_back();
    test_random_gaps();
    test_output_hold();

    while (pending_chars.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);

    $display("converted %0d numbers (%0d negative) into %0d checked characters",
             numbers_sent, negatives_sent, chars_checked);
    $display("edge values, back-to-back input, random gaps and a long output hold-off");
    if (mismatches == 0) begin
      $display("signed_int_to_decimal_ascii_tb: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("signed_int_to_decimal_ascii_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d characters outstanding", pending_chars.size());
    $display("signed_int_to_decimal_ascii_tb: done, errors");
    $finish;
  end

endmodule
